### src/fsfr_pkg.sv
`default_nettype none
package fsfr_pkg;

  localparam int unsigned PREAMBLE_LEN = 2;
  localparam int unsigned MATCH_W = 2;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [8:0] FLETCHER_MOD = 9'd255;
  localparam logic [7:0] POS_MAX = 8'hFF;

  localparam logic [15:0] PREAMBLE_RESET = 16'h5500;
  localparam logic [7:0] DATA_TYPE_RESET = 8'h00;
  localparam logic [7:0] CAN_TYPE_RESET = 8'h01;
  localparam logic [7:0] STRING_TYPE_RESET = 8'h02;

  typedef enum logic [1:0] {
    REG_PREAMBLE    = 2'd0,
    REG_DATA_TYPE   = 2'd1,
    REG_CAN_TYPE    = 2'd2,
    REG_STRING_TYPE = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_TYPE     = 3'd1,
    PH_SEQ      = 3'd2,
    PH_LEN      = 3'd3,
    PH_DATA     = 3'd4,
    PH_CHK_LO   = 3'd5,
    PH_CHK_HI   = 3'd6,
    PH_STRING   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CAN    = 2'd1,
    KIND_STRING = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [15:0] preamble_bytes;
    logic [7:0]  data_type_code;
    logic [7:0]  can_type_code;
    logic [7:0]  string_type_code;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_pos;
    logic        frame_end;
    logic        frame_good;
    frame_kind_t frame_kind;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_len;
  } result_t;

endpackage
`default_nettype wire

### src/fsfr_if.sv
`default_nettype none
interface fsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fsfr_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_pos;
  logic       frame_end;
  logic       frame_good;
  logic [1:0] frame_kind;
  logic [7:0] frame_seq;
  logic [7:0] frame_len;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_pos,
    output frame_end, output frame_good, output frame_kind, output frame_seq,
    output frame_len, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_pos,
    input frame_end, input frame_good, input frame_kind, input frame_seq,
    input frame_len, output ready
  );
endinterface

interface fsfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/serial_frame_receiver_fletcher16_top.sv
// A transferred byte waits in the input register, then its result is registered and offered.
// One byte per cycle unless the output stalls; an empty input register fills during a stall.
// Each byte gives exactly one result, set by the deframer state between the two registers.
// Reset (synchronous, active low) empties both registers, restores the register defaults
// and returns the deframer to preamble search.
`default_nettype none
module serial_frame_receiver_fletcher16_top
  import fsfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fsfr_in_if.sink    in_ch,
  fsfr_out_if.source out_ch,
  fsfr_cfg_if.sink   cfg_ch
);

  cfg_t       cfg;
  result_t    res;
  result_t    out_data_r;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;

  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  fsfr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fsfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.payload_valid = out_data_r.payload_valid;
  assign out_ch.payload_byte = out_data_r.payload_byte;
  assign out_ch.payload_pos = out_data_r.payload_pos;
  assign out_ch.frame_end = out_data_r.frame_end;
  assign out_ch.frame_good = out_data_r.frame_good;
  assign out_ch.frame_kind = out_data_r.frame_kind;
  assign out_ch.frame_seq = out_data_r.frame_seq;
  assign out_ch.frame_len = out_data_r.frame_len;

endmodule
`default_nettype wire

### src/fsfr_cfg.sv
`default_nettype none
module fsfr_cfg
  import fsfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fsfr_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (reg_index_t'(cfg_ch.index))
        REG_PREAMBLE:    cfg_nxt.preamble_bytes = cfg_ch.data;
        REG_DATA_TYPE:   cfg_nxt.data_type_code = cfg_ch.data[7:0];
        REG_CAN_TYPE:    cfg_nxt.can_type_code = cfg_ch.data[7:0];
        REG_STRING_TYPE: cfg_nxt.string_type_code = cfg_ch.data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_bytes <= PREAMBLE_RESET;
      cfg_r.data_type_code <= DATA_TYPE_RESET;
      cfg_r.can_type_code <= CAN_TYPE_RESET;
      cfg_r.string_type_code <= STRING_TYPE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

### src/fsfr_core.sv
`default_nettype none
module fsfr_core
  import fsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  phase_t               phase_r, phase_nxt;
  logic [MATCH_W-1:0]   matched_r, matched_nxt;
  frame_kind_t          kind_r, kind_nxt;
  logic [7:0]           seq_r, seq_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [7:0]           count_r, count_nxt;
  logic [7:0]           sum_lo_r, sum_lo_nxt;
  logic [7:0]           sum_hi_r, sum_hi_nxt;
  logic [7:0]           chk_lo_r, chk_lo_nxt;

  logic                 pre_idx;
  logic [7:0]           pre_byte;
  logic [MATCH_W-1:0]   matched_inc;
  logic [8:0]           lo_add, lo_mod;
  logic [8:0]           hi_add, hi_mod;
  logic [7:0]           count_inc;

  assign pre_idx = (32'(matched_r) >= PREAMBLE_LEN) ? 1'b0 : matched_r[0];
  assign pre_byte = pre_idx ? cfg.preamble_bytes[15:8] : cfg.preamble_bytes[7:0];
  assign matched_inc = {{(MATCH_W-1){1'b0}}, pre_idx} + {{(MATCH_W-1){1'b0}}, 1'b1};

  assign lo_add = {1'b0, sum_lo_r} + {1'b0, rx_byte};
  assign lo_mod = (lo_add >= FLETCHER_MOD) ? lo_add - FLETCHER_MOD : lo_add;
  assign hi_add = {1'b0, sum_hi_r} + {1'b0, lo_mod[7:0]};
  assign hi_mod = (hi_add >= FLETCHER_MOD) ? hi_add - FLETCHER_MOD : hi_add;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    matched_nxt = matched_r;
    kind_nxt = kind_r;
    seq_nxt = seq_r;
    len_nxt = len_r;
    count_nxt = count_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    chk_lo_nxt = chk_lo_r;
    res.payload_valid = 1'b0;
    res.payload_byte = 8'd0;
    res.payload_pos = 8'd0;
    res.frame_end = 1'b0;
    res.frame_good = 1'b0;

    case (phase_r)
      PH_PREAMBLE: begin
        if (rx_byte == pre_byte) begin
          matched_nxt = matched_inc;
        end else begin
          matched_nxt = '0;
        end
        if (32'(matched_nxt) >= PREAMBLE_LEN) begin
          matched_nxt = '0;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (rx_byte == cfg.data_type_code) begin
          kind_nxt = KIND_DATA;
          phase_nxt = PH_SEQ;
        end else if (rx_byte == cfg.can_type_code) begin
          kind_nxt = KIND_CAN;
          phase_nxt = PH_SEQ;
        end else if (rx_byte == cfg.string_type_code) begin
          kind_nxt = KIND_STRING;
          count_nxt = 8'd0;
          phase_nxt = PH_STRING;
        end
      end
      PH_SEQ: begin
        seq_nxt = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        count_nxt = 8'd0;
        sum_lo_nxt = 8'd0;
        sum_hi_nxt = 8'd0;
        phase_nxt = (rx_byte == 8'd0) ? PH_CHK_LO : PH_DATA;
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte = rx_byte;
        res.payload_pos = count_r;
        sum_lo_nxt = lo_mod[7:0];
        sum_hi_nxt = hi_mod[7:0];
        count_nxt = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CHK_LO;
        end
      end
      PH_CHK_LO: begin
        chk_lo_nxt = rx_byte;
        phase_nxt = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        res.frame_end = 1'b1;
        res.frame_good = (chk_lo_r == sum_lo_r) && (rx_byte == sum_hi_r);
        phase_nxt = PH_PREAMBLE;
      end
      PH_STRING: begin
        if (rx_byte != NEWLINE_CHAR) begin
          res.payload_valid = 1'b1;
          res.payload_byte = rx_byte;
          res.payload_pos = count_r;
          if (count_r != POS_MAX) begin
            count_nxt = count_inc;
          end
        end else begin
          res.frame_end = 1'b1;
          res.frame_good = 1'b1;
          phase_nxt = PH_PREAMBLE;
        end
      end
      default: begin
        phase_nxt = PH_PREAMBLE;
      end
    endcase

    res.frame_kind = kind_nxt;
    res.frame_seq = (kind_nxt == KIND_STRING) ? 8'd0 : seq_nxt;
    res.frame_len = (kind_nxt == KIND_STRING) ? 8'd0 : len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      matched_r <= '0;
      kind_r <= KIND_DATA;
      seq_r <= 8'd0;
      len_r <= 8'd0;
      count_r <= 8'd0;
      sum_lo_r <= 8'd0;
      sum_hi_r <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      matched_r <= matched_nxt;
      kind_r <= kind_nxt;
      seq_r <= seq_nxt;
      len_r <= len_nxt;
      count_r <= count_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      chk_lo_r <= chk_lo_nxt;
    end
  end

endmodule
`default_nettype wire

### src/fsfr_checker.sv
`default_nettype none
module fsfr_checker
  import fsfr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       payload_valid,
  input wire logic [7:0] payload_byte,
  input wire logic [7:0] payload_pos,
  input wire logic       frame_end,
  input wire logic       frame_good,
  input wire logic [1:0] frame_kind,
  input wire logic [7:0] frame_seq,
  input wire logic [7:0] frame_len
);

  // A result that was not taken must still be offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A result never flags a byte as both a payload character and a frame terminator.
  a_end_xor_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(payload_valid && frame_end))
    else $error("payload byte flagged as frame end");

  // Good status and payload fields only appear with their qualifiers.
  a_qualified: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_end || !frame_good) &&
      (payload_valid || (payload_byte == 8'd0 && payload_pos == 8'd0)))
    else $error("unqualified status or payload field set");

  // String frames carry no sequence or length.
  a_string_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_kind == KIND_STRING |-> frame_seq == 8'd0 && frame_len == 8'd0)
    else $error("string frame reports header fields");

endmodule

bind serial_frame_receiver_fletcher16_top fsfr_checker u_fsfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_byte  (out_ch.payload_byte),
  .payload_pos   (out_ch.payload_pos),
  .frame_end     (out_ch.frame_end),
  .frame_good    (out_ch.frame_good),
  .frame_kind    (out_ch.frame_kind),
  .frame_seq     (out_ch.frame_seq),
  .frame_len     (out_ch.frame_len)
);
`default_nettype wire
